@@ rtl/core/tilt_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the tilt-angle fusion unit.
// No dependencies.
package tilt_pkg;
	localparam int AccScale = 360;
	localparam int GyroScale = 3932;
	localparam logic [31:0] VarReset = 32'd32768;
	localparam int NumRegs = 7;
	localparam int RegIdxW = 3;
	localparam logic [RegIdxW-1:0] REG_ACCEL_OFFSET = 3'd0;
	localparam logic [RegIdxW-1:0] REG_GYRO_OFFSET = 3'd1;
	localparam logic [RegIdxW-1:0] REG_GYRO_NEGATE = 3'd2;
	localparam logic [RegIdxW-1:0] REG_NOISE_Q = 3'd3;
	localparam logic [RegIdxW-1:0] REG_NOISE_R = 3'd4;
	localparam logic [RegIdxW-1:0] REG_BLEND_GAIN = 3'd5;
	localparam logic [RegIdxW-1:0] REG_STEP_TIME = 3'd6;

	// Request to the Kalman datapath: one scalar filter update.
	typedef struct packed {
		logic start;
		logic signed [31:0] est;
		logic [31:0] var_in;
		logic signed [33:0] meas;
		logic [15:0] q;
		logic [15:0] r;
	} kal_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] est;
		logic [31:0] var_out;
	} kal_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) return 32'h7fffffff;
		if (v < -48'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	// floor(a*k/65536) for a signed a and an unsigned k below 2^18.
	function automatic logic signed [47:0] mulq(input logic signed [47:0] a,
		input logic [17:0] k);
		logic signed [66:0] p;
		p = a * $signed({1'b0, k});
		return p[63:16];
	endfunction
endpackage

@@ rtl/core/tilt_kalman.sv @@
`timescale 1ns / 1ps
// Iterative scalar Kalman update: bit-serial square root and restoring divider.
// Depends on tilt_pkg.
module tilt_kalman import tilt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  kal_req_t req,
	output kal_rsp_t rsp
);
	localparam logic [2:0] S_IDLE = 3'd0, S_SUM = 3'd1, S_SQRT = 3'd2, S_DIV = 3'd3,
		S_EST = 3'd4, S_VAR = 3'd5;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic [63:0] sum_q;
	logic [31:0] root_q;
	logic [49:0] rem_q;
	logic [32:0] den_q;
	logic [16:0] k_q;
	logic signed [31:0] est_q;
	logic [31:0] var_q;
	logic signed [33:0] meas_q;
	logic [15:0] q_q, r_q;
	logic done_q;
	logic [31:0] trial;
	logic [63:0] trial_sq;
	logic [49:0] rem_sh;
	logic [64:0] sum_full;
	logic [49:0] pv;
	logic [4:0] div_bit;

	assign trial = root_q | (32'd1 << cnt_q[4:0]);
	assign trial_sq = trial * trial;
	assign rem_sh = {rem_q[48:0], 1'b0};
	assign sum_full = {33'd0, var_q} * {33'd0, var_q} + {49'd0, q_q} * {49'd0, q_q};
	assign pv = {33'd0, 17'd65536 - k_q} * {18'd0, root_q};
	assign div_bit = 5'(cnt_q - 6'd16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (req.start) begin
					est_q <= req.est;
					var_q <= req.var_in;
					meas_q <= req.meas;
					q_q <= req.q;
					r_q <= req.r;
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q <= sum_full[64] ? '1 : sum_full[63:0];
					root_q <= '0;
					cnt_q <= 6'd31;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (trial_sq <= sum_q) root_q <= trial;
					if (cnt_q == 6'd0) begin
						state_q <= S_DIV;
						cnt_q <= 6'd47;
					end else cnt_q <= cnt_q - 6'd1;
					rem_q <= '0;
					k_q <= '0;
					den_q <= {1'b0, (trial_sq <= sum_q) ? trial : root_q} + {17'd0, r_q};
				end
				S_DIV: begin
					// Dividend root*65536 fed from its top bit down.
					if (den_q == '0) begin
						k_q <= '0;
						state_q <= S_EST;
					end else begin
						logic [49:0] t;
						t = rem_sh | {49'd0, (cnt_q >= 6'd16) ? root_q[div_bit] : 1'b0};
						if (t >= {17'd0, den_q}) begin
							rem_q <= t - {17'd0, den_q};
							k_q <= {k_q[15:0], 1'b1};
						end else begin
							rem_q <= t;
							k_q <= {k_q[15:0], 1'b0};
						end
						if (cnt_q == 6'd0) state_q <= S_EST;
						else cnt_q <= cnt_q - 6'd1;
					end
				end
				S_EST: begin
					est_q <= sat32(48'(est_q) + mulq(48'(meas_q) - 48'(est_q), {1'b0, k_q}));
					state_q <= S_VAR;
				end
				S_VAR: begin
					var_q <= (pv[49:16] > 34'hffffffff) ? '1 : pv[47:16];
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.est = est_q;
	assign rsp.var_out = var_q;
endmodule

@@ rtl/core/tilt_angle_kalman_complementary_fusion_unit.sv @@
`timescale 1ns / 1ps
// Top level of the tilt-angle fusion unit: channel handshakes, registers,
// sequencer and complementary filter. Depends on tilt_pkg and tilt_kalman.
//
// Usage: s_axis carries one word per step with both raw samples. m_axis returns
// one word per step with the filtered accelerometer angle, the filtered gyro
// rate and the fused angle, all signed Q16.16. Configuration writes go through
// cfg_we/cfg_addr/cfg_wdata and must be made while the unit is idle.
// Each word is processed by one shared Kalman unit running twice, each pass a
// bit-serial square root and then a restoring divide, followed by the
// complementary filter arithmetic in states S_C1, S_C2, S_C3 and S_OUT. A pass
// whose divisor is zero skips the divide. The sequencer takes no new word until
// the previous result has been loaded into the output register.
// s_axis_tready is high whenever the sequencer is idle, so a result waiting in
// the output register does not hold off the next word. If the previous result
// is still unaccepted when a new one is due, the sequencer waits in its last
// step until the receiver takes it. Reset returns all registers and filter
// state to their documented defaults and leaves the output empty.
module tilt_angle_kalman_complementary_fusion_unit import tilt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [31:0]   s_axis_tdata,  // accel_sample[15:0], gyro_sample[31:16]
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [95:0]   m_axis_tdata,  // filtered_accel_angle, filtered_gyro_rate, fused_angle
	input  logic          cfg_we,
	input  logic [RegIdxW-1:0] cfg_addr,
	input  logic [15:0]   cfg_wdata
);
	localparam logic [2:0] S_IDLE = 3'd0, S_KA = 3'd1, S_KG = 3'd2, S_C1 = 3'd3,
		S_C2 = 3'd4, S_C3 = 3'd5, S_OUT = 3'd6;

	logic signed [15:0] accel_offset_q, gyro_offset_q;
	logic gyro_negate_q;
	logic [15:0] noise_q_q, noise_r_q, blend_gain_q, step_time_q;
	logic signed [31:0] acc_est_q, rate_est_q, integ_q, fused_q;
	logic [31:0] acc_var_q, rate_var_q;
	logic signed [33:0] angle_q, rate_q;
	logic signed [47:0] e_q, x_q;
	logic [2:0] state_q;
	logic busy_q;
	logic out_valid_q;
	logic [95:0] out_q;
	logic out_load;
	kal_req_t req;
	kal_rsp_t rsp;

	// The configuration port. Writes past the last register fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_offset_q <= '0;
			gyro_offset_q <= 16'sd11;
			gyro_negate_q <= 1'b0;
			noise_q_q <= 16'd328;
			noise_r_q <= 16'd6554;
			blend_gain_q <= 16'd52429;
			step_time_q <= 16'd328;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ACCEL_OFFSET: accel_offset_q <= cfg_wdata;
				REG_GYRO_OFFSET: gyro_offset_q <= cfg_wdata;
				REG_GYRO_NEGATE: gyro_negate_q <= cfg_wdata[0];
				REG_NOISE_Q: noise_q_q <= cfg_wdata;
				REG_NOISE_R: noise_r_q <= cfg_wdata;
				REG_BLEND_GAIN: blend_gain_q <= cfg_wdata;
				REG_STEP_TIME: step_time_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

	// The last step may load the output register once it is empty or being read.
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

	// The shared Kalman unit is started once per filter pass.
	always_comb begin
		req.start = (state_q == S_KA || state_q == S_KG) && !busy_q;
		req.est = (state_q == S_KA) ? acc_est_q : rate_est_q;
		req.var_in = (state_q == S_KA) ? acc_var_q : rate_var_q;
		req.meas = (state_q == S_KA) ? angle_q : rate_q;
		req.q = noise_q_q;
		req.r = noise_r_q;
	end

	tilt_kalman u_kal (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [33:0] ra;
		logic signed [47:0] integ_n;
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			acc_est_q <= '0;
			rate_est_q <= '0;
			integ_q <= '0;
			fused_q <= '0;
			acc_var_q <= VarReset;
			rate_var_q <= VarReset;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			if (req.start) busy_q <= 1'b1;
			case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					angle_q <= (34'($signed(s_axis_tdata[15:0])) - 34'(accel_offset_q))
						* 34'(AccScale);
					ra = (34'($signed(s_axis_tdata[31:16])) - 34'(gyro_offset_q))
						* 34'(GyroScale);
					rate_q <= gyro_negate_q ? -ra : ra;
					state_q <= S_KA;
				end
				S_KA: if (rsp.done) begin
					acc_est_q <= rsp.est;
					acc_var_q <= rsp.var_out;
					busy_q <= 1'b0;
					state_q <= S_KG;
				end
				S_KG: if (rsp.done) begin
					rate_est_q <= rsp.est;
					rate_var_q <= rsp.var_out;
					busy_q <= 1'b0;
					e_q <= 48'(acc_est_q) - 48'(fused_q);
					state_q <= S_C1;
				end
				S_C1: begin
					// First gain product of the integrator term.
					x_q <= mulq(e_q, {2'b0, blend_gain_q});
					state_q <= S_C2;
				end
				S_C2: begin
					x_q <= mulq(x_q, {2'b0, blend_gain_q});
					state_q <= S_C3;
				end
				S_C3: begin
					integ_n = 48'(sat32(48'(integ_q) + mulq(x_q, {2'b0, step_time_q})));
					integ_q <= integ_n[31:0];
					x_q <= integ_n + mulq(e_q, {1'b0, blend_gain_q, 1'b0}) + 48'(rate_est_q);
					state_q <= S_OUT;
				end
				S_OUT: if (out_load) begin
					fused_q <= sat32(48'(fused_q) + mulq(x_q, {2'b0, step_time_q}));
					out_q <= {sat32(48'(fused_q) + mulq(x_q, {2'b0, step_time_q})),
						rate_est_q, acc_est_q};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
